/* hdl/ipde_pkg.sv */
package ipde_pkg;

    localparam int unsigned MarkW  = 12;
    localparam int unsigned SpaceW = 17;
    localparam int unsigned ByteW  = 8;

    // Default depth of the queue between front and back
    localparam int unsigned QueueDepthDefault = 2;

    localparam logic [MarkW-1:0]  HDR0_MARK_US  = MarkW'(3400);
    localparam logic [SpaceW-1:0] HDR0_SPACE_US = SpaceW'(3400);
    localparam logic [MarkW-1:0]  HDR1_MARK_US  = MarkW'(3300);
    localparam logic [SpaceW-1:0] HDR1_SPACE_US = SpaceW'(1700);
    localparam logic [MarkW-1:0]  BIT_MARK_US   = MarkW'(400);
    localparam logic [SpaceW-1:0] ONE_SPACE_US  = SpaceW'(1250);
    localparam logic [SpaceW-1:0] ZERO_SPACE_US = SpaceW'(500);
    localparam logic [SpaceW-1:0] GAP_US        = SpaceW'(100000);

    localparam logic PROTO_MSB_FIRST = 1'b0;
    localparam logic PROTO_LSB_FIRST = 1'b1;

    // One classified byte, bits already in send order (send bit 7 first)
    typedef struct packed {
        logic [ByteW-1:0] bits;
        logic             has_header;
        logic             has_trailer;
        logic             proto;
    } ipde_item_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_HEADER,
        SEQ_BITS,
        SEQ_TRAILER
    } seq_state_t;

endpackage

/* hdl/ir_pulse_distance_frame_encoder.sv */
// Pulse-distance IR frame encoder: takes one frame byte per data transaction
// and produces mark/space pairs in microseconds, one pair per pair transaction.
// A byte flagged first_byte gets a header pair (3400/3400 for protocol 0,
// 3300/1700 for protocol 1), then eight bit pairs of a 400 mark and a 1250
// (one) or 500 (zero) space, MSB first for protocol 0 and LSB first for
// protocol 1; a byte flagged last_byte adds a 400/100000 trailer pair.
// last_of_run marks the final pair of each byte. A byte gives 8 to 10 pairs
// at the output, one pair per cycle while pair_stall is low, paced by the back-end
// sequencer; a byte arriving while the back end is empty is first loaded from the queue.
// A small queue (QUEUE_DEPTH entries) sits between the front end, which holds
// the protocol register and classifies bytes, and the back end, so new bytes
// are taken while earlier ones are still being sent. The protocol is sampled
// when a byte is accepted; write protocol_select only while the block is idle.
module ir_pulse_distance_frame_encoder
    import ipde_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
)
(
    input  logic              clk,
    input  logic              rst_n,
    // data channel
    input  logic              data_valid,
    output logic              data_stall,
    input  logic [ByteW-1:0]  data_byte,
    input  logic              first_byte,
    input  logic              last_byte,
    // configuration write channel
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              protocol_select,
    // pair channel
    output logic              pair_valid,
    input  logic              pair_stall,
    output logic [MarkW-1:0]  mark_us,
    output logic [SpaceW-1:0] space_us,
    output logic              last_of_run
);

    logic       q_full;
    logic       q_push;
    ipde_item_t q_push_item;
    logic       q_pop;
    logic       q_valid;
    ipde_item_t q_head_item;

    // Front end: protocol register, bit-order fixup, push into the queue
    ipde_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .data_valid      (data_valid),
        .data_stall      (data_stall),
        .data_byte       (data_byte),
        .first_byte      (first_byte),
        .last_byte       (last_byte),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .protocol_select (protocol_select),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_item          (q_push_item)
    );

    // Decouple byte intake from pair generation
    ipde_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_item  (q_head_item)
    );

    // Back end: header, bits, trailer sequencer with a registered output
    ipde_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_head_item),
        .q_pop       (q_pop),
        .pair_valid  (pair_valid),
        .pair_stall  (pair_stall),
        .mark_us     (mark_us),
        .space_us    (space_us),
        .last_of_run (last_of_run)
    );

endmodule

/* hdl/ipde_front.sv */
module ipde_front
    import ipde_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             data_valid,
    output logic             data_stall,
    input  logic [ByteW-1:0] data_byte,
    input  logic             first_byte,
    input  logic             last_byte,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             protocol_select,
    input  logic             q_full,
    output logic             q_push,
    output ipde_item_t       q_item
);

    logic             proto_reg;
    logic             proto_next;
    logic [ByteW-1:0] reversed;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        proto_next = proto_reg;
        if (cfg_valid && cfg_ready)
        begin
            proto_next = protocol_select;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            proto_reg <= PROTO_MSB_FIRST;
        end
        else
        begin
            proto_reg <= proto_next;
        end
    end

    // Reverse the byte so the back end always shifts out bit 7 first
    always_comb
    begin
        for (int i = 0; i < ByteW; i++)
        begin
            reversed[i] = data_byte[ByteW-1-i];
        end
    end

    assign data_stall = q_full;
    assign q_push     = data_valid && !q_full;

    always_comb
    begin
        q_item.bits        = (proto_reg == PROTO_LSB_FIRST) ? reversed : data_byte;
        q_item.has_header  = first_byte;
        q_item.has_trailer = last_byte;
        q_item.proto       = proto_reg;
    end

endmodule

/* hdl/ipde_queue.sv */
module ipde_queue
    import ipde_pkg::*;
#(
    parameter int unsigned DEPTH = QueueDepthDefault
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  ipde_item_t push_item,
    output logic       full,
    input  logic       pop,
    output logic       head_valid,
    output ipde_item_t head_item
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    ipde_item_t          slot_reg [DEPTH];
    logic [PtrW-1:0]     wr_ptr_reg;
    logic [PtrW-1:0]     wr_ptr_next;
    logic [PtrW-1:0]     rd_ptr_reg;
    logic [PtrW-1:0]     rd_ptr_next;
    logic [CntW-1:0]     count_reg;
    logic [CntW-1:0]     count_next;

    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
        logic [PtrW-1:0] r;
        if (p == PtrW'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    assign full       = (count_reg == CntW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue pop while empty");

endmodule

/* hdl/ipde_back.sv */
module ipde_back
    import ipde_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  ipde_item_t        q_item,
    output logic              q_pop,
    output logic              pair_valid,
    input  logic              pair_stall,
    output logic [MarkW-1:0]  mark_us,
    output logic [SpaceW-1:0] space_us,
    output logic              last_of_run
);

    seq_state_t        state_reg;
    seq_state_t        state_next;
    logic [ByteW-1:0]  shift_reg;
    logic [ByteW-1:0]  shift_next;
    logic [2:0]        bit_cnt_reg;
    logic [2:0]        bit_cnt_next;
    logic              trailer_reg;
    logic              trailer_next;
    logic              proto_reg;
    logic              proto_next;

    logic              pair_valid_reg;
    logic              pair_valid_next;
    logic [MarkW-1:0]  mark_reg;
    logic [MarkW-1:0]  mark_next;
    logic [SpaceW-1:0] space_reg;
    logic [SpaceW-1:0] space_next;
    logic              last_reg;
    logic              last_next;

    logic              advance;
    logic              emit;
    logic              item_done;

    assign advance = !pair_valid_reg || !pair_stall;

    always_comb
    begin
        state_next      = state_reg;
        shift_next      = shift_reg;
        bit_cnt_next    = bit_cnt_reg;
        trailer_next    = trailer_reg;
        proto_next      = proto_reg;
        mark_next       = mark_reg;
        space_next      = space_reg;
        last_next       = last_reg;
        emit            = 1'b0;
        item_done       = 1'b0;
        q_pop           = 1'b0;

        unique case (state_reg)
            SEQ_IDLE:
            begin
                item_done = 1'b1;
            end
            SEQ_HEADER:
            begin
                if (advance)
                begin
                    emit       = 1'b1;
                    mark_next  = (proto_reg == PROTO_LSB_FIRST) ? HDR1_MARK_US : HDR0_MARK_US;
                    space_next = (proto_reg == PROTO_LSB_FIRST) ? HDR1_SPACE_US
                                                                : HDR0_SPACE_US;
                    last_next  = 1'b0;
                    state_next = SEQ_BITS;
                end
            end
            SEQ_BITS:
            begin
                if (advance)
                begin
                    emit         = 1'b1;
                    mark_next    = BIT_MARK_US;
                    space_next   = shift_reg[ByteW-1] ? ONE_SPACE_US : ZERO_SPACE_US;
                    shift_next   = {shift_reg[ByteW-2:0], 1'b0};
                    bit_cnt_next = bit_cnt_reg + 1'b1;
                    last_next    = 1'b0;
                    if (bit_cnt_reg == 3'd7)
                    begin
                        if (trailer_reg)
                        begin
                            state_next = SEQ_TRAILER;
                        end
                        else
                        begin
                            last_next = 1'b1;
                            item_done = 1'b1;
                        end
                    end
                end
            end
            SEQ_TRAILER:
            begin
                if (advance)
                begin
                    emit       = 1'b1;
                    mark_next  = BIT_MARK_US;
                    space_next = GAP_US;
                    last_next  = 1'b1;
                    item_done  = 1'b1;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase

        // Load the next byte as the current one finishes, or at once when idle
        if (item_done)
        begin
            if (q_valid)
            begin
                q_pop        = 1'b1;
                shift_next   = q_item.bits;
                bit_cnt_next = '0;
                trailer_next = q_item.has_trailer;
                proto_next   = q_item.proto;
                state_next   = q_item.has_header ? SEQ_HEADER : SEQ_BITS;
            end
            else
            begin
                state_next = SEQ_IDLE;
            end
        end

        pair_valid_next = advance ? emit : pair_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= SEQ_IDLE;
            pair_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pair_valid_reg <= pair_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg   <= shift_next;
        bit_cnt_reg <= bit_cnt_next;
        trailer_reg <= trailer_next;
        proto_reg   <= proto_next;
        mark_reg    <= mark_next;
        space_reg   <= space_next;
        last_reg    <= last_next;
    end

    assign pair_valid  = pair_valid_reg;
    assign mark_us     = mark_reg;
    assign space_us    = space_reg;
    assign last_of_run = last_reg;

    a_gap_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (pair_valid_reg && space_reg == GAP_US) |-> last_reg)
        else $error("trailing gap not flagged as end of run");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !last_next) |=> (state_reg != SEQ_IDLE))
        else $error("sequencer went idle in the middle of a byte");

    a_pop_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == SEQ_IDLE || (emit && last_next)))
        else $error("next byte loaded before current byte finished");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import ipde_pkg::*;

    // Cycles with no transaction on any channel before the run is called hung
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    // Long receiver hold-off, long enough to fill the block and stall its input
    localparam int unsigned HOLD_CYCLES    = 120;
    // Quiet cycles after the last expected pair, to catch stray extra pairs
    localparam int unsigned TAIL_CYCLES    = 24;
    localparam int unsigned PHASE_ITEMS    = 85;
    localparam int unsigned DIRECTED_ROWS  = 21;

    // One expected mark/space pair
    typedef struct packed {
        logic [MarkW-1:0]  mark;
        logic [SpaceW-1:0] space;
        logic              tail;
    } pair_t;

    // One row of the directed table. Rows with typed set carry their expected
    // pairs by hand: header mark/space and the one space that every bit uses.
    typedef struct packed {
        logic [ByteW-1:0]  data;
        logic              first;
        logic              last;
        logic              proto;
        logic              typed;
        logic [MarkW-1:0]  hdr_mark;
        logic [SpaceW-1:0] hdr_space;
        logic [SpaceW-1:0] bit_space;
    } dir_row_t;

    logic              clk             = 1'b0;
    logic              rst_n           = 1'b0;
    logic              data_valid      = 1'b0;
    logic              data_stall;
    logic [ByteW-1:0]  data_byte       = '0;
    logic              first_byte      = 1'b0;
    logic              last_byte       = 1'b0;
    logic              cfg_valid       = 1'b0;
    logic              cfg_ready;
    logic              protocol_select = 1'b0;
    logic              pair_valid;
    logic              pair_stall      = 1'b0;
    logic [MarkW-1:0]  mark_us;
    logic [SpaceW-1:0] space_us;
    logic              last_of_run;

    // Testbench copy of the protocol register, updated on each accepted write
    logic        proto_cfg = PROTO_MSB_FIRST;
    // Pairs still owed by the block, oldest first
    pair_t       pairs_due[$];
    int unsigned mismatches = 0;
    logic        idle_on    = 1'b1;
    logic        hold_req   = 1'b0;
    logic        hold_on    = 1'b0;
    int unsigned stall_left = 0;
    int unsigned quiet_cycles = 0;

    // Directed table: extremes of the byte, both protocols, both bit orders,
    // a byte that opens and closes a frame, repeated or missing frame marks,
    // and a protocol change between the opening and closing bytes of a frame.
    dir_row_t dir_rows [0:DIRECTED_ROWS-1] = '{
        '{8'h00, 1'b1, 1'b0, PROTO_MSB_FIRST, 1'b1, 12'd3400, 17'd3400, 17'd500},
        '{8'hFF, 1'b0, 1'b1, PROTO_MSB_FIRST, 1'b1, 12'd0,    17'd0,    17'd1250},
        '{8'hA5, 1'b1, 1'b1, PROTO_MSB_FIRST, 1'b0, 12'd0,    17'd0,    17'd0},
        '{8'h01, 1'b0, 1'b0, PROTO_MSB_FIRST, 1'b0, 12'd0,    17'd0,    17'd0},
        '{8'h80, 1'b0, 1'b0, PROTO_MSB_FIRST, 1'b0, 12'd0,    17'd0,    17'd0},
        '{8'h3C, 1'b1, 1'b0, PROTO_MSB_FIRST, 1'b0, 12'd0,    17'd0,    17'd0},
        '{8'hC3, 1'b1, 1'b0, PROTO_MSB_FIRST, 1'b0, 12'd0,    17'd0,    17'd0},
        '{8'h5A, 1'b0, 1'b1, PROTO_MSB_FIRST, 1'b0, 12'd0,    17'd0,    17'd0},
        '{8'h96, 1'b0, 1'b1, PROTO_MSB_FIRST, 1'b0, 12'd0,    17'd0,    17'd0},
        '{8'h00, 1'b1, 1'b1, PROTO_LSB_FIRST, 1'b1, 12'd3300, 17'd1700, 17'd500},
        '{8'hFF, 1'b1, 1'b0, PROTO_LSB_FIRST, 1'b1, 12'd3300, 17'd1700, 17'd1250},
        '{8'h01, 1'b0, 1'b0, PROTO_LSB_FIRST, 1'b0, 12'd0,    17'd0,    17'd0},
        '{8'h80, 1'b0, 1'b0, PROTO_LSB_FIRST, 1'b0, 12'd0,    17'd0,    17'd0},
        '{8'h6D, 1'b0, 1'b1, PROTO_LSB_FIRST, 1'b0, 12'd0,    17'd0,    17'd0},
        '{8'hFF, 1'b0, 1'b1, PROTO_LSB_FIRST, 1'b1, 12'd0,    17'd0,    17'd1250},
        '{8'h12, 1'b0, 1'b0, PROTO_LSB_FIRST, 1'b0, 12'd0,    17'd0,    17'd0},
        '{8'h81, 1'b1, 1'b0, PROTO_MSB_FIRST, 1'b0, 12'd0,    17'd0,    17'd0},
        '{8'h7E, 1'b0, 1'b1, PROTO_LSB_FIRST, 1'b0, 12'd0,    17'd0,    17'd0},
        '{8'h00, 1'b0, 1'b0, PROTO_LSB_FIRST, 1'b1, 12'd0,    17'd0,    17'd500},
        '{8'hFF, 1'b1, 1'b1, PROTO_MSB_FIRST, 1'b1, 12'd3400, 17'd3400, 17'd1250},
        '{8'h00, 1'b0, 1'b0, PROTO_MSB_FIRST, 1'b1, 12'd0,    17'd0,    17'd500}
    };

    ir_pulse_distance_frame_encoder DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .data_valid      (data_valid),
        .data_stall      (data_stall),
        .data_byte       (data_byte),
        .first_byte      (first_byte),
        .last_byte       (last_byte),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .protocol_select (protocol_select),
        .pair_valid      (pair_valid),
        .pair_stall      (pair_stall),
        .mark_us         (mark_us),
        .space_us        (space_us),
        .last_of_run     (last_of_run)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Work out the pairs one byte produces and queue them: optional header,
    // eight bit pairs in the order the protocol sends them, optional trailer.
    // The final pair of the byte carries the tail flag.
    function automatic void encode_byte_pairs(input logic [ByteW-1:0] data,
                                              input logic first, input logic last,
                                              input logic proto);
        pair_t p;
        logic  bit_val;
        if (first)
        begin
            if (proto == PROTO_LSB_FIRST)
                p = '{HDR1_MARK_US, HDR1_SPACE_US, 1'b0};
            else
                p = '{HDR0_MARK_US, HDR0_SPACE_US, 1'b0};
            pairs_due.push_back(p);
        end
        for (int k = 0; k < 8; k++)
        begin
            bit_val = (proto == PROTO_LSB_FIRST) ? data[k] : data[7-k];
            p.mark  = BIT_MARK_US;
            p.space = bit_val ? ONE_SPACE_US : ZERO_SPACE_US;
            p.tail  = (k == 7) && !last;
            pairs_due.push_back(p);
        end
        if (last)
        begin
            p = '{BIT_MARK_US, GAP_US, 1'b1};
            pairs_due.push_back(p);
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $realtime, msg);
        mismatches++;
    endtask

    // Offer one byte and hold it until the block takes it. When predict is
    // set, queue the predicted pairs at acceptance, using the protocol in force.
    task automatic send_byte(input logic [ByteW-1:0] data, input logic first,
                             input logic last, input logic predict);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            data_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        data_valid <= 1'b1;
        data_byte  <= data;
        first_byte <= first;
        last_byte  <= last;
        @(posedge clk);
        while (data_stall)
            @(posedge clk);
        if (predict)
            encode_byte_pairs(data, first, last, proto_cfg);
    endtask

    // Drop valid and wait until every owed pair has come back
    task automatic drain;
        data_valid <= 1'b0;
        while (pairs_due.size() != 0)
            @(posedge clk);
    endtask

    // Write the protocol register; only call with the block idle
    task automatic write_protocol(input logic proto);
        cfg_valid       <= 1'b1;
        protocol_select <= proto;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        proto_cfg = proto;
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed frames of 1 to 12 bytes with random content; about
    // one frame in five gets random first/last marks instead.
    task automatic send_random_frames(input int unsigned n_items);
        int unsigned sent;
        int unsigned frame_len;
        logic        broken;
        logic        first;
        logic        last;
        sent = 0;
        while (sent < n_items)
        begin
            frame_len = $urandom_range(1, 12);
            broken    = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < frame_len && sent < n_items; k++)
            begin
                first = (k == 0);
                last  = (k == frame_len - 1);
                if (broken)
                begin
                    first = 1'($urandom_range(0, 1));
                    last  = 1'($urandom_range(0, 1));
                end
                send_byte(8'($urandom_range(0, 255)), first, last, 1'b1);
                sent++;
            end
        end
    endtask

    // Pair receiver: check each accepted pair against the oldest expectation,
    // then pick the stall for the next cycle (random bursts plus the long hold).
    always @(posedge clk)
    begin
        pair_t want;
        logic  burst;
        if (!rst_n)
        begin
            pair_stall <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (pair_valid && !pair_stall)
            begin
                if (pairs_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected pair %0d/%0d",
                                              mark_us, space_us));
                end
                else
                begin
                    want = pairs_due.pop_front();
                    if (mark_us !== want.mark)
                        report_mismatch($sformatf("mark_us mismatch: got %0d, expected %0d",
                                                  mark_us, want.mark));
                    if (space_us !== want.space)
                        report_mismatch($sformatf("space_us mismatch: got %0d, expected %0d",
                                                  space_us, want.space));
                    if (last_of_run !== want.tail)
                        report_mismatch($sformatf(
                            "last_of_run mismatch: got %0d, expected %0d",
                            last_of_run, want.tail));
                end
            end
            burst = 1'b0;
            if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                burst = 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left <= $urandom_range(0, 7);
                burst = 1'b1;
            end
            pair_stall <= burst || hold_on;
        end
    end

    // Long hold-off, counted here: the sender keeps offering bytes meanwhile
    initial
    begin
        @(posedge hold_req);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
    end

    // Watchdog: count cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if ((data_valid && !data_stall) || (pair_valid && !pair_stall) ||
            (cfg_valid && cfg_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t ns: watchdog expired, %0d pairs outstanding", $realtime,
                     pairs_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        dir_row_t row;
        pair_t    p;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Start from the reset value, written explicitly
        write_protocol(PROTO_MSB_FIRST);

        // Directed table: switch protocol only once the block is drained
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            row = dir_rows[i];
            if (row.proto != proto_cfg)
            begin
                drain();
                write_protocol(row.proto);
            end
            if (row.typed)
            begin
                // Hand-typed pairs; queue them ahead since all earlier bytes
                // already have their pairs queued.
                if (row.first)
                begin
                    p = '{row.hdr_mark, row.hdr_space, 1'b0};
                    pairs_due.push_back(p);
                end
                for (int k = 0; k < 8; k++)
                begin
                    p = '{12'd400, row.bit_space, (k == 7) && !row.last};
                    pairs_due.push_back(p);
                end
                if (row.last)
                begin
                    p = '{12'd400, 17'd100000, 1'b1};
                    pairs_due.push_back(p);
                end
                send_byte(row.data, row.first, row.last, 1'b0);
            end
            else
                send_byte(row.data, row.first, row.last, 1'b1);
        end
        drain();

        // Random phase 1: LSB-first, with the long receiver hold at its start
        write_protocol(PROTO_LSB_FIRST);
        hold_req <= 1'b1;
        send_random_frames(PHASE_ITEMS);
        drain();

        write_protocol(PROTO_MSB_FIRST);
        send_random_frames(PHASE_ITEMS);
        drain();

        write_protocol(PROTO_LSB_FIRST);
        send_random_frames(PHASE_ITEMS);
        drain();

        // Last phase: random protocol, both sides at full rate
        idle_on <= 1'b0;
        write_protocol(1'($urandom_range(0, 1)));
        send_random_frames(PHASE_ITEMS);
        drain();

        // Hold on a little longer to catch stray extra pairs
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
